/* rtl/ggbl_pkg.sv */
// Shared types and constants for the geoid grid bilinear lookup.
`default_nettype none

package ggbl_pkg;

   // What one input item asks for.
   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_ORIGIN_LAT  = 3'd0,
      CSR_ORIGIN_LON  = 3'd1,
      CSR_LAT_STEP    = 3'd2,
      CSR_LON_STEP    = 3'd3,
      CSR_ROW_COUNT   = 3'd4,
      CSR_COL_COUNT   = 3'd5,
      CSR_EDGE_MARGIN = 3'd6
   } csr_index_type;

   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 1024;

   localparam int HEIGHT_W = 32;
   localparam int STEP_W   = 26;
   localparam int COUNT_W  = 11;
   // Holds a clamped count up to the largest supported grid side.
   localparam int CNT_W    = 14;
   localparam int CSR_W    = 31;

   // Magnitude and quotient widths of the interpolation divide.
   localparam int MAG_W    = 60;
   localparam int LERP_QW  = 33;

   // 360 degrees in position units.
   localparam logic signed [32:0] FULL_TURN = 33'sd1509949440;

   localparam logic [29:0] RST_ORIGIN_LAT  = 30'd0;
   localparam logic [30:0] RST_ORIGIN_LON  = 31'd0;
   localparam logic [25:0] RST_LAT_STEP    = 26'd69905;
   localparam logic [25:0] RST_LON_STEP    = 26'd69905;
   localparam logic [10:0] RST_ROW_COUNT   = 11'd1024;
   localparam logic [10:0] RST_COL_COUNT   = 11'd1024;
   localparam logic [25:0] RST_EDGE_MARGIN = 26'd419430;

endpackage

`default_nettype wire

/* rtl/ggbl_div.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`default_nettype none

module ggbl_div #(
   parameter int LANES = 1,
   parameter int NW    = 34,
   parameter int DW    = 26,
   parameter int QW    = 10,
   parameter int PW    = 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [LANES-1:0][NW-1:0]  num,
   // The user holds the divisor steady while items are in flight; not enforced.
   input  wire logic [LANES-1:0][DW-1:0]  den,
   input  wire logic [PW-1:0]             in_pay,
   output logic                           out_valid,
   output logic [LANES-1:0][QW-1:0]       quo,
   output logic [LANES-1:0][DW-1:0]       rem,
   output logic [PW-1:0]                  out_pay
);

   logic [NW-1:0] rem_ff [QW][LANES];
   logic [QW-1:0] quo_ff [QW][LANES];
   logic          vld_ff [QW];
   logic [PW-1:0] pay_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vld_src;
      logic [PW-1:0] pay_src;

      if (k == 0) begin : g_first
         assign vld_src = in_valid;
         assign pay_src = in_pay;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign pay_src = pay_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         pay_ff[k] <= pay_src;
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [NW-1:0] rem_src;
         logic [NW-1:0] rem_in;
         logic [NW-1:0] den_ext;
         logic [QW-1:0] quo_src;
         logic [QW-1:0] quo_in;
         logic          fits;

         if (k == 0) begin : g_first
            assign rem_src = num[l];
            assign quo_src = '0;
         end else begin : g_next
            assign rem_src = rem_ff[k-1][l];
            assign quo_src = quo_ff[k-1][l];
         end

         assign den_ext = NW'(den[l]);
         assign fits    = (rem_src >> (QW - 1 - k)) >= den_ext;
         assign rem_in  = fits ? rem_src - (den_ext << (QW - 1 - k)) : rem_src;
         assign quo_in  = QW'({quo_src, fits});

         always_ff @(posedge clock) begin
            rem_ff[k][l] <= rem_in;
            quo_ff[k][l] <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign quo[l] = quo_ff[QW-1][l];
      assign rem[l] = rem_ff[QW-1][l][DW-1:0];
   end

endmodule

`default_nettype wire

/* rtl/ggbl_lerp.sv */
// Pipelined linear interpolation a + frac*(b-a)/den, rounded half up, several lanes.
`default_nettype none

module ggbl_lerp #(
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        in_valid,
   input  wire logic [LANES-1:0][ggbl_pkg::HEIGHT_W-1:0]    a,
   input  wire logic [LANES-1:0][ggbl_pkg::HEIGHT_W-1:0]    b,
   input  wire logic [LANES-1:0][ggbl_pkg::STEP_W-1:0]      frac,
   input  wire logic [ggbl_pkg::STEP_W-1:0]                 den,
   input  wire logic [PW-1:0]                               in_pay,
   output logic                                             out_valid,
   output logic [LANES-1:0][ggbl_pkg::HEIGHT_W-1:0]         h,
   output logic [PW-1:0]                                    out_pay
);

   localparam int HW  = ggbl_pkg::HEIGHT_W;
   localparam int FW  = ggbl_pkg::STEP_W;
   localparam int MW  = ggbl_pkg::MAG_W;
   localparam int QW  = ggbl_pkg::LERP_QW;
   localparam int DW  = FW + 1;
   localparam int SW  = HW + 1;
   localparam int DPW = PW + LANES * SW;

   logic          vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic [PW-1:0] pay1_ff, pay2_ff, pay3_ff, pay4_ff;

   logic [LANES-1:0][MW-1:0] div_num;
   logic [LANES-1:0][DW-1:0] div_den;
   logic [LANES-1:0][SW-1:0] side3;
   logic [LANES-1:0][SW-1:0] side_d;
   logic [LANES-1:0][QW-1:0] div_quo;
   logic [LANES-1:0][DW-1:0] div_rem;
   logic [DPW-1:0]           div_pay;
   logic                     div_vld;
   logic signed [DW-1:0]     den_s;

   assign den_s = $signed({1'b0, den});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      pay1_ff <= in_pay;
      pay2_ff <= pay1_ff;
      pay3_ff <= pay2_ff;
      pay4_ff <= div_pay[DPW-1:LANES*SW];
   end

   assign side_d = div_pay[LANES*SW-1:0];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic        [HW-1:0]   a1_ff, a2_ff, a3_ff, h_ff;
      logic        [FW-1:0]   frac1_ff;
      logic signed [SW-1:0]   diff1_ff;
      logic signed [SW-1:0]   diff_in;
      logic signed [FW:0]     frac_s;
      logic signed [MW-1:0]   num2_ff;
      logic signed [MW-1:0]   num_in;
      logic signed [MW+1:0]   n_in;
      logic signed [MW+1:0]   n_abs;
      logic                   neg3_ff;
      logic        [MW-1:0]   mag3_ff;
      logic signed [QW:0]     q_s;
      logic signed [QW:0]     res;
      logic signed [QW:0]     h_in;

      assign diff_in = $signed(b[l]) - $signed(a[l]);
      assign frac_s  = $signed({1'b0, frac1_ff});
      assign num_in  = frac_s * diff1_ff;
      // Doubling numerator and denominator turns rounding half up into a floor.
      assign n_in    = (num2_ff <<< 1) + den_s;
      assign n_abs   = n_in[MW+1] ? -n_in : n_in;

      always_ff @(posedge clock) begin
         a1_ff    <= a[l];
         frac1_ff <= frac[l];
         diff1_ff <= diff_in;
         a2_ff    <= a1_ff;
         num2_ff  <= num_in;
         a3_ff    <= a2_ff;
         neg3_ff  <= n_in[MW+1];
         mag3_ff  <= n_abs[MW-1:0];
      end

      assign div_num[l] = mag3_ff;
      assign div_den[l] = {den, 1'b0};
      assign side3[l]   = {neg3_ff, a3_ff};

      // A negative quotient with a remainder floors one further down.
      assign q_s  = $signed({1'b0, div_quo[l]});
      assign res  = side_d[l][HW] ? ((div_rem[l] != '0) ? -(q_s + 1) : -q_s) : q_s;
      assign h_in = $signed(side_d[l][HW-1:0]) + res;

      always_ff @(posedge clock) begin
         h_ff <= h_in[HW-1:0];
      end

      assign h[l] = h_ff;
   end

   ggbl_div #(
      .LANES (LANES),
      .NW    (MW),
      .DW    (DW),
      .QW    (QW),
      .PW    (DPW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld3_ff),
      .num       (div_num),
      .den       (div_den),
      .in_pay    ({pay3_ff, side3}),
      .out_valid (div_vld),
      .quo       (div_quo),
      .rem       (div_rem),
      .out_pay   (div_pay)
   );

   assign out_valid = vld4_ff;
   assign out_pay   = pay4_ff;

endmodule

`default_nettype wire

/* rtl/ggbl_grid.sv */
// Height grid split into even and odd address banks, each with two read ports.
`default_nettype none

module ggbl_grid #(
   parameter int DEPTH = ggbl_pkg::DEF_MAX_ROWS * ggbl_pkg::DEF_MAX_COLS
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [ggbl_pkg::HEIGHT_W-1:0] wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_base,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_up,
   output logic      [ggbl_pkg::HEIGHT_W-1:0] ll,
   output logic      [ggbl_pkg::HEIGHT_W-1:0] lr,
   output logic      [ggbl_pkg::HEIGHT_W-1:0] ul,
   output logic      [ggbl_pkg::HEIGHT_W-1:0] ur
);

   localparam int AW         = $clog2(DEPTH);
   localparam int BANK_DEPTH = (DEPTH + 1) / 2;
   localparam int HW         = ggbl_pkg::HEIGHT_W;

   logic [HW-1:0] even_mem [BANK_DEPTH];
   logic [HW-1:0] odd_mem  [BANK_DEPTH];

   logic [AW:0]   base_inc;
   logic [AW:0]   up_inc;
   logic [HW-1:0] lo_even_ff, lo_odd_ff, up_even_ff, up_odd_ff;
   logic          base_par_ff, up_par_ff;

   // Of two neighbouring entries one is even and one odd: the even one sits at (n+1)/2.
   assign base_inc = {1'b0, rd_base} + 1'b1;
   assign up_inc   = {1'b0, rd_up} + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_addr[0]) begin
         even_mem[wr_addr[AW-1:1]] <= wr_data;
      end
      if (rd_en) begin
         lo_even_ff <= even_mem[base_inc[AW-1:1]];
         up_even_ff <= even_mem[up_inc[AW-1:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr[0]) begin
         odd_mem[wr_addr[AW-1:1]] <= wr_data;
      end
      if (rd_en) begin
         lo_odd_ff <= odd_mem[rd_base[AW-1:1]];
         up_odd_ff <= odd_mem[rd_up[AW-1:1]];
      end
   end

   always_ff @(posedge clock) begin
      base_par_ff <= rd_base[0];
      up_par_ff   <= rd_up[0];
   end

   assign ll = base_par_ff ? lo_odd_ff  : lo_even_ff;
   assign lr = base_par_ff ? lo_even_ff : lo_odd_ff;
   assign ul = up_par_ff   ? up_odd_ff  : up_even_ff;
   assign ur = up_par_ff   ? up_even_ff : up_odd_ff;

endmodule

`default_nettype wire

/* rtl/geoid_grid_bilinear_lookup.sv */
// Top level of the geoid grid bilinear lookup: bounds check, cell index, grid read, interpolation.
//
//   channel  ports                                   handshake
//   request  req_action .. req_query_lon             start high, busy low
//   result   rsp_height, rsp_in_tile                 rsp_valid for one cycle
//   config   csr_index, csr_write_data               csr_write_enable
//
// One item enters every cycle; busy stays low. A query answers once it has passed the
// bounds stages, the cell index divide, the grid read and the two interpolation steps:
// the cell index divide gives one bit a stage, and each of the two interpolation
// steps spends 33 stages in its rounding divide. A grid write lands in the grid
// at the same stage as a query reads it, so items keep their order.
// Reset clears the pipeline valid bits and presets the config registers; the grid is not cleared.
`default_nettype none

module geoid_grid_bilinear_lookup #(
   parameter int MAX_ROWS = ggbl_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = ggbl_pkg::DEF_MAX_COLS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [19:0]                   req_entry_index,
   input  wire logic [31:0]                   req_entry_height,
   input  wire logic [29:0]                   req_query_lat,
   input  wire logic [31:0]                   req_query_lon,
   output logic                               rsp_valid,
   output logic [31:0]                        rsp_height,
   output logic                               rsp_in_tile,
   input  wire logic                          csr_write_enable,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [ggbl_pkg::CSR_W-1:0]    csr_write_data
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int IQ    = ($clog2(MAX_ROWS) > $clog2(MAX_COLS)) ?
                          $clog2(MAX_ROWS) : $clog2(MAX_COLS);
   localparam int FW    = ggbl_pkg::STEP_W;
   localparam int HW    = ggbl_pkg::HEIGHT_W;
   localparam int CW    = ggbl_pkg::CNT_W;
   localparam int DNW   = 34;
   localparam int IPW   = 2 + 20 + HW;
   localparam int LAT   = 6 + IQ + 2 * (ggbl_pkg::LERP_QW + 4);

   // Configuration registers.
   logic [29:0]   origin_lat_ff;
   logic [30:0]   origin_lon_ff;
   logic [FW-1:0] lat_step_ff;
   logic [FW-1:0] lon_step_ff;
   logic [10:0]   row_count_ff;
   logic [10:0]   col_count_ff;
   logic [FW-1:0] edge_margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_lat_ff  <= ggbl_pkg::RST_ORIGIN_LAT;
         origin_lon_ff  <= ggbl_pkg::RST_ORIGIN_LON;
         lat_step_ff    <= ggbl_pkg::RST_LAT_STEP;
         lon_step_ff    <= ggbl_pkg::RST_LON_STEP;
         row_count_ff   <= ggbl_pkg::RST_ROW_COUNT;
         col_count_ff   <= ggbl_pkg::RST_COL_COUNT;
         edge_margin_ff <= ggbl_pkg::RST_EDGE_MARGIN;
      end else if (csr_write_enable) begin
         case (csr_index)
            ggbl_pkg::CSR_ORIGIN_LAT:  origin_lat_ff  <= csr_write_data[29:0];
            ggbl_pkg::CSR_ORIGIN_LON:  origin_lon_ff  <= csr_write_data[30:0];
            ggbl_pkg::CSR_LAT_STEP:    lat_step_ff    <= csr_write_data[FW-1:0];
            ggbl_pkg::CSR_LON_STEP:    lon_step_ff    <= csr_write_data[FW-1:0];
            ggbl_pkg::CSR_ROW_COUNT:   row_count_ff   <= csr_write_data[10:0];
            ggbl_pkg::CSR_COL_COUNT:   col_count_ff   <= csr_write_data[10:0];
            ggbl_pkg::CSR_EDGE_MARGIN: edge_margin_ff <= csr_write_data[FW-1:0];
            default: ;
         endcase
      end
   end

   // Counts in use, clamped to the grid that is built.
   logic [CW-1:0] rows, cols;
   assign rows = (CW'(row_count_ff) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(row_count_ff);
   assign cols = (CW'(col_count_ff) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(col_count_ff);

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 1: longitude wrap and tile spans.
   logic                 p1_vld_ff, p1_act_ff;
   logic [19:0]          p1_idx_ff;
   logic [HW-1:0]        p1_hgt_ff;
   logic signed [29:0]   p1_lat_ff;
   logic signed [32:0]   p1_lon_ff;
   logic [39:0]          p1_span_lat_ff, p1_span_lon_ff;
   logic signed [32:0]   lon_in;
   logic [39:0]          span_lat_in, span_lon_in;

   assign lon_in      = $signed(req_query_lon) +
                        (req_query_lon[31] ? ggbl_pkg::FULL_TURN : 33'sd0);
   assign span_lat_in = lat_step_ff * rows;
   assign span_lon_in = lon_step_ff * cols;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      p1_act_ff      <= req_action;
      p1_idx_ff      <= req_entry_index;
      p1_hgt_ff      <= req_entry_height;
      p1_lat_ff      <= $signed(req_query_lat);
      p1_lon_ff      <= lon_in;
      p1_span_lat_ff <= span_lat_in;
      p1_span_lon_ff <= span_lon_in;
   end

   // Stage 2: shrunk bounds and offsets from the origin.
   logic                 p2_vld_ff, p2_act_ff;
   logic [19:0]          p2_idx_ff;
   logic [HW-1:0]        p2_hgt_ff;
   logic signed [29:0]   p2_lat_ff;
   logic signed [32:0]   p2_lon_ff;
   logic signed [41:0]   p2_lat_lo_ff, p2_lat_hi_ff, p2_lon_lo_ff, p2_lon_hi_ff;
   logic signed [DNW-1:0] p2_dlat_ff, p2_dlon_ff;
   logic signed [29:0]   olat_s;
   logic signed [31:0]   olon_s;
   logic signed [FW:0]   margin_s;
   logic signed [40:0]   span_lat_s, span_lon_s;
   logic signed [41:0]   lat_lo_in, lat_hi_in, lon_lo_in, lon_hi_in;
   logic signed [DNW-1:0] dlat_in, dlon_in;

   assign olat_s     = $signed(origin_lat_ff);
   assign olon_s     = $signed({1'b0, origin_lon_ff});
   assign margin_s   = $signed({1'b0, edge_margin_ff});
   assign span_lat_s = $signed({1'b0, p1_span_lat_ff});
   assign span_lon_s = $signed({1'b0, p1_span_lon_ff});
   assign lat_lo_in  = olat_s + margin_s;
   assign lat_hi_in  = olat_s + span_lat_s - margin_s;
   assign lon_lo_in  = olon_s + margin_s;
   assign lon_hi_in  = olon_s + span_lon_s - margin_s;
   assign dlat_in    = p1_lat_ff - olat_s;
   assign dlon_in    = p1_lon_ff - olon_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_act_ff    <= p1_act_ff;
      p2_idx_ff    <= p1_idx_ff;
      p2_hgt_ff    <= p1_hgt_ff;
      p2_lat_ff    <= p1_lat_ff;
      p2_lon_ff    <= p1_lon_ff;
      p2_lat_lo_ff <= lat_lo_in;
      p2_lat_hi_ff <= lat_hi_in;
      p2_lon_lo_ff <= lon_lo_in;
      p2_lon_hi_ff <= lon_hi_in;
      p2_dlat_ff   <= dlat_in;
      p2_dlon_ff   <= dlon_in;
   end

   // Stage 3: bounds test. A zero step leaves the bounds empty, so it fails here too.
   logic                 p3_vld_ff, p3_act_ff, p3_ok_ff;
   logic [19:0]          p3_idx_ff;
   logic [HW-1:0]        p3_hgt_ff;
   logic [DNW-1:0]       p3_dlat_ff, p3_dlon_ff;
   logic                 ok3_in;

   assign ok3_in = (p2_lat_ff > p2_lat_lo_ff) && (p2_lat_ff < p2_lat_hi_ff) &&
                   (p2_lon_ff > p2_lon_lo_ff) && (p2_lon_ff < p2_lon_hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_act_ff  <= p2_act_ff;
      p3_ok_ff   <= ok3_in;
      p3_idx_ff  <= p2_idx_ff;
      p3_hgt_ff  <= p2_hgt_ff;
      p3_dlat_ff <= p2_dlat_ff;
      p3_dlon_ff <= p2_dlon_ff;
   end

   // Row and column by division; lane 0 is latitude, lane 1 longitude.
   logic [1:0][DNW-1:0] idx_num;
   logic [1:0][FW-1:0]  idx_den;
   logic [1:0][IQ-1:0]  idx_quo;
   logic [1:0][FW-1:0]  idx_rem;
   logic [IPW-1:0]      idx_pay;
   logic                idx_vld;

   assign idx_num = {p3_dlon_ff, p3_dlat_ff};
   assign idx_den = {lon_step_ff, lat_step_ff};

   ggbl_div #(
      .LANES (2),
      .NW    (DNW),
      .DW    (FW),
      .QW    (IQ),
      .PW    (IPW)
   ) u_index_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p3_vld_ff),
      .num       (idx_num),
      .den       (idx_den),
      .in_pay    ({p3_act_ff, p3_ok_ff, p3_idx_ff, p3_hgt_ff}),
      .out_valid (idx_vld),
      .quo       (idx_quo),
      .rem       (idx_rem),
      .out_pay   (idx_pay)
   );

   // Stage 4: neighbour check and cell base address.
   logic                 p4_vld_ff, p4_act_ff, p4_ok_ff;
   logic [19:0]          p4_idx_ff;
   logic [HW-1:0]        p4_hgt_ff;
   logic [AW-1:0]        p4_base_ff;
   logic [FW-1:0]        p4_rl_ff, p4_rc_ff;
   logic                 ok4_in;
   logic [27:0]          base_full;

   assign ok4_in    = idx_pay[IPW-2] &&
                      ((CW+1)'(idx_quo[0]) + 1'b1 < (CW+1)'(rows)) &&
                      ((CW+1)'(idx_quo[1]) + 1'b1 < (CW+1)'(cols));
   assign base_full = idx_quo[0] * cols + idx_quo[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else begin
         p4_vld_ff <= idx_vld;
      end
   end

   always_ff @(posedge clock) begin
      p4_act_ff  <= idx_pay[IPW-1];
      p4_ok_ff   <= ok4_in;
      p4_idx_ff  <= idx_pay[HW+19:HW];
      p4_hgt_ff  <= idx_pay[HW-1:0];
      p4_base_ff <= base_full[AW-1:0];
      p4_rl_ff   <= idx_rem[0];
      p4_rc_ff   <= idx_rem[1];
   end

   // Grid access: writes and reads meet the grid at the same stage.
   logic          wr_en, rd_en;
   logic [27:0]   up_full;
   logic [HW-1:0] g_ll, g_lr, g_ul, g_ur;

   assign wr_en   = p4_vld_ff && (p4_act_ff == ggbl_pkg::ACT_WRITE) &&
                    (32'(p4_idx_ff) < 32'(DEPTH));
   assign rd_en   = p4_vld_ff && (p4_act_ff == ggbl_pkg::ACT_QUERY);
   assign up_full = 28'(p4_base_ff) + 28'(cols);

   ggbl_grid #(
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(p4_idx_ff)),
      .wr_data (p4_hgt_ff),
      .rd_en   (rd_en),
      .rd_base (p4_base_ff),
      .rd_up   (up_full[AW-1:0]),
      .ll      (g_ll),
      .lr      (g_lr),
      .ul      (g_ul),
      .ur      (g_ur)
   );

   // Stage 5 runs beside the grid read register; only queries go on from here.
   logic          p5_vld_ff, p5_ok_ff;
   logic [FW-1:0] p5_rl_ff, p5_rc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_vld_ff <= 1'b0;
      end else begin
         p5_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      p5_ok_ff <= p4_ok_ff;
      p5_rl_ff <= p4_rl_ff;
      p5_rc_ff <= p4_rc_ff;
   end

   // Along latitude: lane 0 is the left column, lane 1 the right.
   logic                l1_vld;
   logic [1:0][HW-1:0]  l1_h;
   logic [FW:0]         l1_pay;

   ggbl_lerp #(
      .LANES (2),
      .PW    (FW + 1)
   ) u_lat_lerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p5_vld_ff),
      .a         ({g_lr, g_ll}),
      .b         ({g_ur, g_ul}),
      .frac      ({p5_rl_ff, p5_rl_ff}),
      .den       (lat_step_ff),
      .in_pay    ({p5_ok_ff, p5_rc_ff}),
      .out_valid (l1_vld),
      .h         (l1_h),
      .out_pay   (l1_pay)
   );

   // Along longitude between the two column results.
   logic                l2_vld;
   logic [0:0][HW-1:0]  l2_h;
   logic                l2_ok;

   ggbl_lerp #(
      .LANES (1),
      .PW    (1)
   ) u_lon_lerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l1_vld),
      .a         (l1_h[0]),
      .b         (l1_h[1]),
      .frac      (l1_pay[FW-1:0]),
      .den       (lon_step_ff),
      .in_pay    (l1_pay[FW]),
      .out_valid (l2_vld),
      .h         (l2_h),
      .out_pay   (l2_ok)
   );

   // Result register.
   logic          rsp_valid_ff, rsp_in_tile_ff;
   logic [HW-1:0] rsp_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= l2_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_in_tile_ff <= l2_ok;
      rsp_height_ff  <= l2_ok ? l2_h[0] : '0;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_in_tile = rsp_in_tile_ff;
   assign rsp_height  = rsp_height_ff;

   // Every query item answers after the fixed latency, and a write item answers never.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == ggbl_pkg::ACT_QUERY) |-> ##LAT rsp_valid)
      else $error("query item did not answer after the pipeline latency");

   assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == ggbl_pkg::ACT_WRITE) |-> ##LAT !rsp_valid)
      else $error("write item produced a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_tile |-> rsp_height == '0)
      else $error("point outside the tile gave a non-zero height");

   assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##LAT !rsp_valid)
      else $error("result appeared without an item");

endmodule

`default_nettype wire

/* tb/geoid_grid_bilinear_lookup_tb.sv */
// Self-checking testbench for the geoid grid bilinear lookup with its own height predictor.
`timescale 1ns / 1ps

module geoid_grid_bilinear_lookup_tb;
   import ggbl_pkg::*;

   localparam longint TURN = 64'sd1509949440;
   localparam int GRID_SIDE = 1024;
   localparam int SETTLE_CYCLES = 120;
   localparam longint CYCLE_LIMIT = 3000000;

   class height_scoreboard;
      int failures;
      logic [29:0] origin_lat;
      logic [30:0] origin_lon;
      logic [25:0] lat_step, lon_step, edge_margin;
      logic [10:0] row_count, col_count;
      int grid [int];
      logic [31:0] height_q [$];
      logic in_tile_q [$];

      function void set_reg(csr_index_type idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_ORIGIN_LAT:  origin_lat = v[29:0];
            CSR_ORIGIN_LON:  origin_lon = v[30:0];
            CSR_LAT_STEP:    lat_step = v[25:0];
            CSR_LON_STEP:    lon_step = v[25:0];
            CSR_ROW_COUNT:   row_count = v[10:0];
            CSR_COL_COUNT:   col_count = v[10:0];
            CSR_EDGE_MARGIN: edge_margin = v[25:0];
            default: ;
         endcase
      endfunction

      function longint floor_div(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q = q - 1;
         return q;
      endfunction

      // Rounds to nearest with ties towards plus infinity.
      function longint blend(longint a, longint b, longint frac, longint den);
         return a + floor_div(2 * frac * (b - a) + den, 2 * den);
      endfunction

      function longint grid_at(longint addr);
         int key;
         key = int'(addr % (GRID_SIDE * GRID_SIDE));
         return grid.exists(key) ? longint'(grid[key]) : 0;
      endfunction

      function void note_item(action_type act, logic [19:0] idx, logic [31:0] h,
                              logic [29:0] qlat, logic [31:0] qlon);
         longint lat, lon, olat, olon, ls, os, m, rows, cols, row, col, rl, rc;
         longint base, left, right;
         if (act == ACT_WRITE) begin
            grid[int'(idx)] = int'(h);
            return;
         end
         lat = longint'(signed'(qlat));
         lon = longint'(signed'(qlon));
         if (lon < 0) lon = lon + TURN;
         olat = longint'(signed'(origin_lat));
         olon = longint'(origin_lon);
         ls = lat_step;
         os = lon_step;
         m = edge_margin;
         rows = (row_count > GRID_SIDE) ? GRID_SIDE : row_count;
         cols = (col_count > GRID_SIDE) ? GRID_SIDE : col_count;
         if (ls == 0 || os == 0 || !(lat > olat + m && lat < olat + ls * rows - m &&
             lon > olon + m && lon < olon + os * cols - m)) begin
            height_q.push_back(32'd0);
            in_tile_q.push_back(1'b0);
            return;
         end
         row = (lat - olat) / ls;
         col = (lon - olon) / os;
         if (row + 1 >= rows || col + 1 >= cols) begin
            height_q.push_back(32'd0);
            in_tile_q.push_back(1'b0);
            return;
         end
         rl = lat - olat - row * ls;
         rc = lon - olon - col * os;
         base = row * cols + col;
         left = blend(grid_at(base), grid_at(base + cols), rl, ls);
         right = blend(grid_at(base + 1), grid_at(base + cols + 1), rl, ls);
         height_q.push_back(32'(blend(left, right, rc, os)));
         in_tile_q.push_back(1'b1);
      endfunction

      function void check_result(logic [31:0] h, logic it);
         if (height_q.size() == 0) begin
            $error("result with no query outstanding: height %0d in_tile %0b", h, it);
            failures++;
            return;
         end
         if (h !== height_q[0]) begin
            $error("height: expected %0d actual %0d", $signed(height_q[0]), $signed(h));
            failures++;
         end
         if (it !== in_tile_q[0]) begin
            $error("in_tile: expected %0b actual %0b", in_tile_q[0], it);
            failures++;
         end
         void'(height_q.pop_front());
         void'(in_tile_q.pop_front());
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic [19:0] req_entry_index = '0;
   logic [31:0] req_entry_height = '0;
   logic [29:0] req_query_lat = '0;
   logic [31:0] req_query_lon = '0;
   logic rsp_valid, rsp_in_tile;
   logic [31:0] rsp_height;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CSR_W-1:0] csr_write_data = '0;

   height_scoreboard tracker;
   longint cycles = 0;
   bit steady;

   geoid_grid_bilinear_lookup dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset) begin
         if (start && !busy)
            tracker.note_item(action_type'(req_action), req_entry_index, req_entry_height,
                              req_query_lat, req_query_lon);
         if (rsp_valid) tracker.check_result(rsp_height, rsp_in_tile);
      end
   end

   // Called just after a rising edge; returns just after the edge that took the item.
   task automatic send(action_type act, logic [19:0] idx, logic [31:0] h,
                       logic [29:0] qlat, logic [31:0] qlon);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_action <= act;
      req_entry_index <= idx;
      req_entry_height <= h;
      req_query_lat <= qlat;
      req_query_lon <= qlon;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic put_entry(logic [19:0] idx, logic [31:0] h);
      send(ACT_WRITE, idx, h, 30'($urandom), $urandom);
   endtask

   task automatic ask(longint lat, longint lon);
      send(ACT_QUERY, 20'($urandom), $urandom, 30'(lat), 32'(lon));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (tracker.height_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The caller drops the write enable after its last register write.
   task automatic set_csr(csr_index_type idx, longint v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_W'(v);
      tracker.set_reg(idx, CSR_W'(v));
      @(posedge clock);
   endtask

   function automatic longint pick(longint span);
      return longint'({$urandom, $urandom} >> 1) % (span + 1);
   endfunction

   // Queries keep to rows from lo_row and columns from lo_col, less one for the edge.
   task automatic run_tile(longint olat, longint olon, longint ls, longint os,
                           longint rows, longint cols, longint m, longint lo_row,
                           longint lo_col, int queries);
      longint rc, cc, lat, lon, r0, c0;
      int roll;
      set_csr(CSR_ORIGIN_LAT, olat);
      set_csr(CSR_ORIGIN_LON, olon);
      set_csr(CSR_LAT_STEP, ls);
      set_csr(CSR_LON_STEP, os);
      set_csr(CSR_ROW_COUNT, rows);
      set_csr(CSR_COL_COUNT, cols);
      set_csr(CSR_EDGE_MARGIN, m);
      csr_write_enable <= 1'b0;
      steady = ($urandom_range(0, 3) == 0);
      rc = (rows > GRID_SIDE) ? GRID_SIDE : rows;
      cc = (cols > GRID_SIDE) ? GRID_SIDE : cols;
      r0 = (lo_row > 0) ? lo_row - 1 : 0;
      c0 = (lo_col > 0) ? lo_col - 1 : 0;
      // Every entry that a query can reach is written first, so none reads a fresh entry.
      for (longint r = r0; r < rc; r++)
         for (longint c = c0; c < cc; c++) put_entry(20'(r * cc + c), $urandom);
      for (int n = 0; n < queries; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) put_entry(20'($urandom), $urandom);
         else if (roll < 15 && lo_row == 0 && lo_col == 0)
            ask(longint'($urandom), longint'($urandom));
         else begin
            lat = olat + ls * (lo_row - 1) + pick(ls * (rc - lo_row) + 2 * ls);
            lon = olon + os * (lo_col - 1) + pick(os * (cc - lo_col) + 2 * os);
            if ($urandom_range(0, 3) == 0) lon = lon - TURN;
            ask(lat, lon);
         end
      end
      drain();
   endtask

   initial begin
      longint ls, os, rows, cols, olat, olon;
      tracker = new();
      tracker.set_reg(CSR_ORIGIN_LAT, RST_ORIGIN_LAT);
      tracker.set_reg(CSR_ORIGIN_LON, RST_ORIGIN_LON);
      tracker.set_reg(CSR_LAT_STEP, RST_LAT_STEP);
      tracker.set_reg(CSR_LON_STEP, RST_LON_STEP);
      tracker.set_reg(CSR_ROW_COUNT, RST_ROW_COUNT);
      tracker.set_reg(CSR_COL_COUNT, RST_COL_COUNT);
      tracker.set_reg(CSR_EDGE_MARGIN, RST_EDGE_MARGIN);
      steady = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings cover a large tile, so only queries outside it are sent here.
      put_entry(20'd0, 32'h7FFF_FFFF);
      put_entry(20'hFFFFF, 32'h8000_0000);
      ask(-377487360, 100);
      ask(377487360, 1509949440);
      ask(100, -754974720);
      ask(100, -64'sd2147483648);
      ask(0, 0);
      drain();

      // Smallest steps and counts at the southern limit.
      run_tile(-377487360, 0, 1, 1, 2, 2, 0, 0, 0, 12);
      // Largest steps near the eastern limit.
      run_tile(-200000000, 1509949440 - 83886080, 41943040, 41943040, 2, 2, 0, 0, 0, 25);
      // Row and column counts beyond the grid side are clamped; queries keep to the far edge.
      run_tile(-300000000, 1000, 300, 100000, 2047, 2, 5, 1016, 0, 40);
      run_tile(1000, 2000, 100000, 300, 2, 2047, 20, 0, 1016, 40);
      // Counts below two leave no neighbour.
      run_tile(0, 0, 1000, 1000, 1, 0, 0, 0, 0, 15);
      // A zero step or a margin wider than the tile leaves no bounds at all.
      run_tile(0, 0, 0, 1000, 4, 4, 0, 0, 0, 10);
      run_tile(0, 0, 1000, 1000, 4, 4, 41943040, 0, 0, 10);

      for (int p = 0; p < 22; p++) begin
         rows = $urandom_range(2, 8);
         cols = $urandom_range(2, 8);
         ls = $urandom_range(1, $urandom_range(0, 1) ? 5000 : 700000000 / rows);
         if (ls > 41943040) ls = 41943040;
         os = $urandom_range(1, $urandom_range(0, 1) ? 5000 : 41943040);
         olat = -377487360 + pick(754974720 - ls * rows);
         olon = pick(1509949440 - os * cols);
         run_tile(olat, olon, ls, os, rows, cols, pick(ls / 2), 0, 0, 45);
      end

      if (tracker.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
